/* hdl/tsd_pkg.sv */
`timescale 1ns / 1ps

package tsd_pkg;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [31:0] CP_MAX = 32'h0010_FFFF;
	localparam logic [31:0] SUR_LO = 32'h0000_D800;
	localparam logic [31:0] SUR_HI = 32'h0000_DFFF;
	localparam logic [2:0]  RUN_MAX   = 3'd5;
	localparam logic [2:0]  RUN_CLOSE = 3'd3;

	localparam int MAX_RES = 4;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_OPEN = 4'd1,
		PH_LEAD = 4'd2,
		PH_BODY = 4'd3,
		PH_ESC  = 4'd4,
		PH_HEX  = 4'd5,
		PH_RUN  = 4'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNTERM    = 3'd1,
		ST_NEWLINE   = 3'd2,
		ST_BAD_ESC   = 3'd3,
		ST_BAD_HEX   = 3'd4,
		ST_BAD_CP    = 3'd5,
		ST_QUOTE_RUN = 3'd6,
		ST_NO_QUOTE  = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       source_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       token_done;
		status_t    status;
		logic [1:0] string_kind;
		logic       not_consumed;
		logic       last;
	} out_beat_t;

	typedef struct packed {
		logic    drop;
		logic    fin;
		status_t st;
		logic    esc;
		logic    run;
	} body_res_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	// bit 4 flags a non-hex character
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b0, d[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b0, d[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b0, d[3:0]};
		end
		return 5'h10;
	endfunction

	function automatic body_res_t body_fn(input logic [7:0] c, input logic skip,
			input logic ml, input logic lit);
		body_res_t r;
		logic [7:0] qc;
		r = '{drop: 1'b0, fin: 1'b0, st: ST_OK, esc: 1'b0, run: 1'b0};
		qc = lit ? CH_SQUOTE : CH_DQUOTE;
		if (skip && is_blank(c)) begin
			r.drop = 1'b1;
		end else if (!ml && c == CH_LF) begin
			r.fin = 1'b1;
			r.st  = ST_NEWLINE;
		end else if (!lit && c == CH_BSLASH) begin
			r.esc = 1'b1;
		end else if (c == qc) begin
			if (!ml) begin
				r.fin = 1'b1;
			end else begin
				r.run = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

/* hdl/toml_string_scan_decode.sv */
// Stages: an accepted input beat is registered into stage 1, and its result beats
// into the result buffer. Throughput: one input beat per cycle while out_ready is
// high and each item yields at most one result; an item yielding several results
// (UTF-8 sequences, closing quote runs) holds the input stage while the result buffer
// drains one beat per cycle while out_ready is high. Reset: arst_n clears the token
// state to idle, empties both stages and sets emit_q to 1.
`timescale 1ns / 1ps

module toml_string_scan_decode import tsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);

	logic emit_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	phase_t      phase_q, nx_phase;
	logic        lit_q, nx_lit;
	logic        ml_q, nx_ml;
	logic [1:0]  oqc_q, nx_oqc;
	logic [2:0]  crc_q, nx_crc;
	logic [3:0]  hex_q, nx_hex;
	logic [31:0] cp_q, nx_cp;
	logic        pcr_q, nx_pcr;
	logic        skip_q, nx_skip;

	out_beat_t res_q [MAX_RES];
	logic [2:0] cnt_q;

	logic [7:0]  rb [MAX_RES];
	logic [2:0]  r_n;
	logic        fin;
	status_t     fst;
	logic        fnc;
	logic        do_body;
	body_res_t   bd;
	logic [7:0]  qc;
	logic [4:0]  hv;
	logic [31:0] acc;
	logic [3:0]  hl;

	out_beat_t res_c [MAX_RES];
	logic [2:0] e_n;
	logic [2:0] n_res;
	logic       buf_free;
	logic       fire;

	assign qc = lit_q ? CH_SQUOTE : CH_DQUOTE;
	assign bd = body_fn(byte_s1, skip_q, ml_q, lit_q);
	assign hv = hex_val(byte_s1);
	assign acc = {cp_q[27:0], hv[3:0]};

	// next token state and raw content bytes
	always_comb begin
		nx_phase = phase_q;
		nx_lit   = lit_q;
		nx_ml    = ml_q;
		nx_oqc   = oqc_q;
		nx_crc   = crc_q;
		nx_hex   = hex_q;
		nx_cp    = cp_q;
		nx_pcr   = pcr_q;
		nx_skip  = skip_q;
		for (int i = 0; i < MAX_RES; i++) begin
			rb[i] = 8'h00;
		end
		r_n     = 3'd0;
		fin     = 1'b0;
		fst     = ST_OK;
		fnc     = 1'b0;
		do_body = 1'b0;
		hl      = 4'd0;
		if (end_s1) begin
			fin = 1'b1;
			if (phase_q == PH_IDLE) begin
				fst = ST_NO_QUOTE;
			end else if (phase_q == PH_OPEN && oqc_q == 2'd2) begin
				fst = ST_OK;
			end else if (phase_q == PH_RUN && crc_q >= RUN_CLOSE) begin
				fst = ST_OK;
				for (int k = 0; k < 2; k++) begin
					if (3'(k) + RUN_CLOSE < crc_q) begin
						rb[r_n[1:0]] = qc;
						r_n = r_n + 3'd1;
					end
				end
			end else begin
				fst = ST_UNTERM;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE) begin
						nx_lit   = (byte_s1 == CH_SQUOTE);
						nx_ml    = 1'b0;
						nx_oqc   = 2'd1;
						nx_crc   = 3'd0;
						nx_hex   = 4'd0;
						nx_cp    = 32'd0;
						nx_pcr   = 1'b0;
						nx_skip  = 1'b0;
						nx_phase = PH_OPEN;
					end else begin
						fin = 1'b1;
						fst = ST_NO_QUOTE;
					end
				end
				PH_OPEN: begin
					if (byte_s1 == qc) begin
						if (oqc_q < 2'd2) begin
							nx_oqc = 2'd2;
						end else begin
							nx_oqc   = 2'd3;
							nx_ml    = 1'b1;
							nx_phase = PH_LEAD;
						end
					end else if (oqc_q < 2'd2) begin
						nx_phase = PH_BODY;
						do_body  = 1'b1;
					end else begin
						fin = 1'b1;
						fnc = 1'b1;
					end
				end
				PH_LEAD: begin
					if (pcr_q) begin
						nx_pcr   = 1'b0;
						nx_phase = PH_BODY;
						if (byte_s1 != CH_LF) begin
							rb[r_n[1:0]] = CH_CR;
							r_n = r_n + 3'd1;
							do_body = 1'b1;
						end
					end else if (byte_s1 == CH_CR) begin
						nx_pcr = 1'b1;
					end else begin
						nx_phase = PH_BODY;
						do_body  = (byte_s1 != CH_LF);
					end
				end
				PH_BODY: begin
					do_body = 1'b1;
				end
				PH_ESC: begin
					nx_phase = PH_BODY;
					case (byte_s1)
						8'h62: begin rb[r_n[1:0]] = 8'h08; r_n = r_n + 3'd1; end
						8'h74: begin rb[r_n[1:0]] = 8'h09; r_n = r_n + 3'd1; end
						8'h6E: begin rb[r_n[1:0]] = 8'h0A; r_n = r_n + 3'd1; end
						8'h66: begin rb[r_n[1:0]] = 8'h0C; r_n = r_n + 3'd1; end
						8'h72: begin rb[r_n[1:0]] = 8'h0D; r_n = r_n + 3'd1; end
						CH_DQUOTE: begin rb[r_n[1:0]] = CH_DQUOTE; r_n = r_n + 3'd1; end
						CH_BSLASH: begin rb[r_n[1:0]] = CH_BSLASH; r_n = r_n + 3'd1; end
						8'h75, 8'h55: begin
							nx_hex   = (byte_s1 == 8'h75) ? 4'd4 : 4'd8;
							nx_cp    = 32'd0;
							nx_phase = PH_HEX;
						end
						default: begin
							if (ml_q && is_blank(byte_s1)) begin
								nx_skip = 1'b1;
							end else begin
								fin = 1'b1;
								fst = ST_BAD_ESC;
							end
						end
					endcase
				end
				PH_HEX: begin
					if (hv[4]) begin
						fin = 1'b1;
						fst = ST_BAD_HEX;
					end else begin
						hl     = (hex_q != 4'd0) ? hex_q - 4'd1 : 4'd0;
						nx_cp  = acc;
						nx_hex = hl;
						if (hl == 4'd0) begin
							if (acc > CP_MAX || (acc >= SUR_LO && acc <= SUR_HI)) begin
								fin = 1'b1;
								fst = ST_BAD_CP;
							end else begin
								nx_phase = PH_BODY;
								if (acc < 32'h80) begin
									rb[0] = acc[7:0];
									r_n   = 3'd1;
								end else if (acc < 32'h800) begin
									rb[0] = {3'b110, acc[10:6]};
									rb[1] = {2'b10, acc[5:0]};
									r_n   = 3'd2;
								end else if (acc < 32'h10000) begin
									rb[0] = {4'b1110, acc[15:12]};
									rb[1] = {2'b10, acc[11:6]};
									rb[2] = {2'b10, acc[5:0]};
									r_n   = 3'd3;
								end else begin
									rb[0] = {5'b11110, acc[20:18]};
									rb[1] = {2'b10, acc[17:12]};
									rb[2] = {2'b10, acc[11:6]};
									rb[3] = {2'b10, acc[5:0]};
									r_n   = 3'd4;
								end
							end
						end
					end
				end
				PH_RUN: begin
					if (byte_s1 == qc) begin
						nx_crc = crc_q + 3'd1;
						if (crc_q + 3'd1 > RUN_MAX) begin
							fin = 1'b1;
							fst = ST_QUOTE_RUN;
						end
					end else if (crc_q >= RUN_CLOSE) begin
						for (int k = 0; k < 2; k++) begin
							if (3'(k) + RUN_CLOSE < crc_q) begin
								rb[r_n[1:0]] = qc;
								r_n = r_n + 3'd1;
							end
						end
						fin = 1'b1;
						fnc = 1'b1;
					end else begin
						for (int k = 0; k < 2; k++) begin
							if (3'(k) < crc_q) begin
								rb[r_n[1:0]] = qc;
								r_n = r_n + 3'd1;
							end
						end
						nx_crc   = 3'd0;
						nx_phase = PH_BODY;
						do_body  = 1'b1;
					end
				end
				default: begin
					nx_phase = PH_IDLE;
					nx_lit   = 1'b0;
					nx_ml    = 1'b0;
					nx_oqc   = 2'd0;
					nx_crc   = 3'd0;
					nx_hex   = 4'd0;
					nx_cp    = 32'd0;
					nx_pcr   = 1'b0;
					nx_skip  = 1'b0;
				end
			endcase
			if (do_body && !bd.drop) begin
				nx_skip = 1'b0;
				if (bd.fin) begin
					fin = 1'b1;
					fst = bd.st;
				end else if (bd.esc) begin
					nx_phase = PH_ESC;
				end else if (bd.run) begin
					nx_crc   = 3'd1;
					nx_phase = PH_RUN;
				end else begin
					rb[r_n[1:0]] = byte_s1;
					r_n = r_n + 3'd1;
				end
			end
		end
		if (fin) begin
			nx_phase = PH_IDLE;
			nx_lit   = 1'b0;
			nx_ml    = 1'b0;
			nx_oqc   = 2'd0;
			nx_crc   = 3'd0;
			nx_hex   = 4'd0;
			nx_cp    = 32'd0;
			nx_pcr   = 1'b0;
			nx_skip  = 1'b0;
		end
	end

	// result beats of the item in stage 1
	always_comb begin
		e_n   = emit_q ? r_n : 3'd0;
		n_res = e_n + {2'b00, fin};
		for (int i = 0; i < MAX_RES; i++) begin
			res_c[i].out_byte     = 8'h00;
			res_c[i].byte_valid   = 1'b0;
			res_c[i].token_done   = 1'b0;
			res_c[i].status       = ST_OK;
			res_c[i].string_kind  = {ml_q, lit_q};
			res_c[i].not_consumed = 1'b0;
			res_c[i].last         = (3'(i) + 3'd1 == n_res);
			if (3'(i) < e_n) begin
				res_c[i].out_byte   = rb[i];
				res_c[i].byte_valid = 1'b1;
			end else if (fin && 3'(i) == e_n) begin
				res_c[i].token_done   = 1'b1;
				res_c[i].status       = fst;
				res_c[i].not_consumed = fnc;
			end
		end
	end

	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = res_q[0];
	assign buf_free  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);
	assign fire      = valid_s1 && (n_res == 3'd0 || buf_free);
	assign in_ready  = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b1;
		end else if (cfg_wr_en) begin
			emit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_data.in_byte;
			end_s1  <= in_data.source_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lit_q   <= 1'b0;
			ml_q    <= 1'b0;
			oqc_q   <= 2'd0;
			crc_q   <= 3'd0;
			hex_q   <= 4'd0;
			cp_q    <= 32'd0;
			pcr_q   <= 1'b0;
			skip_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= nx_phase;
			lit_q   <= nx_lit;
			ml_q    <= nx_ml;
			oqc_q   <= nx_oqc;
			crc_q   <= nx_crc;
			hex_q   <= nx_hex;
			cp_q    <= nx_cp;
			pcr_q   <= nx_pcr;
			skip_q  <= nx_skip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (fire && n_res != 3'd0) begin
			cnt_q <= n_res;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// result buffer shifts towards slot 0 as beats leave
	always_ff @(posedge clk) begin
		if (fire && n_res != 3'd0) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= res_c[i];
			end
		end else if (out_valid && out_ready) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

endmodule
